[rtl/tsm_pkg.sv]
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants of the triangle similarity matcher
// Entry and result layouts, opcodes, register indexes, sine coefficients.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	// divider geometry: Q16.16 over Q16.16 gives a 48-bit dividend
	localparam int DVD_W = 48;
	localparam int DVS_W = 32;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MID_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHT_TOL = 2'd1;
	localparam logic [15:0] TOL_RESET = 16'd655;

	// quarter-wave sine polynomial, Q30
	localparam logic [30:0] SIN_A = 31'd1686629713;
	localparam logic [29:0] SIN_B = 30'd688904866;
	localparam logic [26:0] SIN_C = 27'd76016977;
	localparam logic [15:0] QUARTER = 16'd16384;

	typedef struct packed {
		logic [31:0] long_side;
		logic [15:0] orientation;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] mid_ratio;
		logic [15:0] sht_ratio;
	} entry_t;

	typedef struct packed {
		logic [31:0] scale_ratio;
		logic [15:0] rotation;
		logic [31:0] shift_x;
		logic [31:0] shift_y;
	} result_t;

endpackage

[rtl/tsm_cell.sv]
// ----------------------------------------------------------------------------
// tsm_cell: one table slot of the entry chain
// Takes its upper neighbor on a push and its lower neighbor on a rotate.
// ----------------------------------------------------------------------------
module tsm_cell (
	input  logic            clk,
	input  logic            push_en,
	input  logic            rot_en,
	input  tsm_pkg::entry_t push_in,
	input  tsm_pkg::entry_t rot_in,
	output tsm_pkg::entry_t entry
);

	tsm_pkg::entry_t entry_q;

	// shift toward the tail on a push, toward the head on a rotate
	always_ff @(posedge clk) begin
		if (push_en) begin
			entry_q <= push_in;
		end else if (rot_en) begin
			entry_q <= rot_in;
		end
	end

	assign entry = entry_q;

endmodule

[rtl/tsm_div.sv]
// ----------------------------------------------------------------------------
// tsm_div: restoring divider, one quotient bit per cycle
// 48-bit dividend over a nonzero 32-bit divisor, done pulses once the last quotient bit is in.
// ----------------------------------------------------------------------------
module tsm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tsm_pkg::DVD_W-1:0] dividend,
	input  logic [tsm_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [tsm_pkg::DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(tsm_pkg::DVD_W + 1);

	logic [tsm_pkg::DVD_W-1:0] dvd_q;
	logic [tsm_pkg::DVS_W-1:0] dvs_q;
	logic [tsm_pkg::DVS_W-1:0] rem_q;
	logic [STEP_W-1:0]         step_q;
	logic                      busy_q;
	logic                      done_q;
	logic [tsm_pkg::DVS_W:0]   trial;
	logic                      qbit;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, dvd_q[tsm_pkg::DVD_W-1]};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	// shift the quotient in where the dividend leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				dvd_q  <= dividend;
				dvs_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= qbit ? tsm_pkg::DVS_W'(trial - {1'b0, dvs_q})
				               : trial[tsm_pkg::DVS_W-1:0];
				dvd_q  <= {dvd_q[tsm_pkg::DVD_W-2:0], qbit};
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(tsm_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/tsm_sine.sv]
// ----------------------------------------------------------------------------
// tsm_sine: Q30 sine of a binary angle
// Quarter-wave polynomial evaluated one product per cycle, quadrant folded.
// ----------------------------------------------------------------------------
module tsm_sine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] angle,
	output logic        done,
	output logic [31:0] value
);

	typedef enum logic [2:0] {
		SN_IDLE, SN_X2, SN_INNER, SN_MID, SN_OUT
	} sn_state_t;

	sn_state_t   state_q;
	logic [14:0] t_q;
	logic        neg_q;
	logic [14:0] x2_q;
	logic [29:0] inner_q;
	logic [30:0] mid_q;
	logic [31:0] value_q;
	logic        done_q;

	logic [29:0] t_sq;
	logic [41:0] x2_c;
	logic [44:0] x2_in;
	logic [45:0] t_mid;
	logic [30:0] s_mag;

	always_comb begin
		t_sq  = t_q * t_q;
		x2_c  = x2_q * tsm_pkg::SIN_C;
		x2_in = x2_q * inner_q;
		t_mid = t_q * mid_q;
		s_mag = t_mid[44:14];
	end

	// one polynomial product per state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SN_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SN_IDLE: begin
					if (start) begin
						t_q     <= angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]})
						                     : {1'b0, angle[13:0]};
						neg_q   <= angle[15];
						state_q <= SN_X2;
					end
				end
				SN_X2: begin
					x2_q    <= t_sq[28:14];
					state_q <= SN_INNER;
				end
				SN_INNER: begin
					inner_q <= tsm_pkg::SIN_B - x2_c[41:14];
					state_q <= SN_MID;
				end
				SN_MID: begin
					mid_q   <= tsm_pkg::SIN_A - x2_in[44:14];
					state_q <= SN_OUT;
				end
				SN_OUT: begin
					value_q <= neg_q ? 32'(-{1'b0, s_mag}) : {1'b0, s_mag};
					done_q  <= 1'b1;
					state_q <= SN_IDLE;
				end
				default: state_q <= SN_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign value = value_q;

endmodule

[rtl/triangle_similarity_matcher_top.sv]
// Load: two shape-ratio divisions, then ready again.
// Query: two divisions for its own ratios, a scan over every table slot of the
//   entry chain (TABLE_DEPTH), and per match a scale division, two sine
//   evaluations and eight products; clear and ignored words return to idle.
// One word is in work at a time; results leave through a one-word output register.
// Reset (arst_n low) empties the table and restores both tolerances to 655.
// ----------------------------------------------------------------------------
// triangle_similarity_matcher_top: reference triangle table and matcher
// A chain of cells holds the entries newest first and rotates past a shared
// divider, sine unit and multiplier datapath during a query.
// ----------------------------------------------------------------------------
module triangle_similarity_matcher_top #(
	parameter int TABLE_DEPTH = tsm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [31:0]                   long_side,
	input  logic [31:0]                   middle_side,
	input  logic [31:0]                   short_side,
	input  logic signed [15:0]            orientation,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   scale_ratio,
	output logic signed [15:0]            rotation,
	output logic signed [31:0]            shift_x,
	output logic signed [31:0]            shift_y,
	output logic                          last_match,
	input  logic                          cfg_wr_en,
	input  logic [tsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_DIV_M, ST_DIV_S, ST_PUSH, ST_SCAN, ST_DIV_R,
		ST_SIN_S, ST_SIN_C, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_ROT,
		ST_SCL0, ST_SCL1, ST_SCL2, ST_SCL3, ST_FIN, ST_EMIT, ST_FLUSH
	} state_t;

	state_t state_q;

	// latched input word
	logic [1:0]  op_q;
	logic [31:0] lng_q, mid_q, sht_q, px_q, py_q;
	logic [15:0] ang_q;
	logic [15:0] mr_q, sr_q;
	logic [15:0] tol_m_q, tol_s_q;
	logic [CNT_W-1:0] count_q, scan_q;

	// shared units
	logic                      div_go_q, div_done;
	logic [tsm_pkg::DVD_W-1:0] div_dvd_q, div_quot;
	logic [tsm_pkg::DVS_W-1:0] div_dvs_q;
	logic                      sin_go_q, sin_done;
	logic [15:0]               sin_ang_q;
	logic [31:0]               sin_val;

	// match datapath
	logic [31:0]        r_q;
	logic [15:0]        dphi_q;
	logic signed [31:0] s_q, c_q;
	logic signed [63:0] p0_q, p1_q, p2_q, p3_q;
	logic               xneg_q, yneg_q;
	logic [32:0]        xmag_q, ymag_q;
	logic [48:0]        sxh_q, sxl_q, syh_q, syl_q;

	tsm_pkg::result_t res_q, pend_q, out_q;
	logic             pend_v_q, out_valid_q, last_q;

	// entry chain
	tsm_pkg::entry_t cells [TABLE_DEPTH];
	tsm_pkg::entry_t new_entry, head;
	logic            push_en, rot_en, hit, slot_free;
	logic [15:0]     dm, ds;

	// combinational datapath pieces
	logic signed [64:0] vx, vy;
	logic [64:0]        ax_mag, ay_mag;
	logic [49:0]        px_prod, py_prod;
	logic signed [51:0] dx, dy;
	logic [31:0]        sat_x, sat_y;

	assign head = cells[0];

	always_comb begin
		new_entry.long_side   = lng_q;
		new_entry.orientation = ang_q;
		new_entry.pos_x       = px_q;
		new_entry.pos_y       = py_q;
		new_entry.mid_ratio   = mr_q;
		new_entry.sht_ratio   = sr_q;
	end

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			tsm_pkg::entry_t push_src;
			if (gi == 0) begin : g_head
				assign push_src = new_entry;
			end else begin : g_body
				assign push_src = cells[gi-1];
			end
			tsm_cell u_cell (
				.clk     (clk),
				.push_en (push_en),
				.rot_en  (rot_en),
				.push_in (push_src),
				.rot_in  (cells[(gi + 1) % TABLE_DEPTH]),
				.entry   (cells[gi])
			);
		end
	endgenerate

	tsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	tsm_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sin_go_q),
		.angle  (sin_ang_q),
		.done   (sin_done),
		.value  (sin_val)
	);

	// compare the head entry's shape ratios against the query's
	always_comb begin
		dm  = (head.mid_ratio > mr_q) ? 16'(head.mid_ratio - mr_q) : 16'(mr_q - head.mid_ratio);
		ds  = (head.sht_ratio > sr_q) ? 16'(head.sht_ratio - sr_q) : 16'(sr_q - head.sht_ratio);
		hit = (scan_q < count_q) && (dm < tol_m_q) && (ds < tol_s_q);
		slot_free = !out_valid_q || !out_stall;
		push_en = (state_q == ST_PUSH);
		rot_en  = ((state_q == ST_SCAN) && (scan_q != CNT_W'(TABLE_DEPTH)) && !hit) ||
		          ((state_q == ST_EMIT) && (!pend_v_q || slot_free));
	end

	// rotate, then scale, subtract and saturate
	always_comb begin
		vx = {p0_q[63], p0_q} - {p1_q[63], p1_q};
		vy = {p2_q[63], p2_q} + {p3_q[63], p3_q};
		ax_mag = vx[64] ? 65'(-vx) : 65'(vx);
		ay_mag = vy[64] ? 65'(-vy) : 65'(vy);
		px_prod = {1'b0, sxh_q} + 50'(sxl_q[48:16]);
		py_prod = {1'b0, syh_q} + 50'(syl_q[48:16]);
		dx = 52'($signed(px_q)) - (xneg_q ? -$signed({2'b00, px_prod}) : $signed({2'b00, px_prod}));
		dy = 52'($signed(py_q)) - (yneg_q ? -$signed({2'b00, py_prod}) : $signed({2'b00, py_prod}));
		if (dx > 52'sd2147483647) begin
			sat_x = 32'h7FFF_FFFF;
		end else if (dx < -52'sd2147483648) begin
			sat_x = 32'h8000_0000;
		end else begin
			sat_x = dx[31:0];
		end
		if (dy > 52'sd2147483647) begin
			sat_y = 32'h7FFF_FFFF;
		end else if (dy < -52'sd2147483648) begin
			sat_y = 32'h8000_0000;
		end else begin
			sat_y = dy[31:0];
		end
	end

	// hold tolerances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_m_q <= tsm_pkg::TOL_RESET;
			tol_s_q <= tsm_pkg::TOL_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_index == tsm_pkg::REG_MID_TOL) begin
				tol_m_q <= cfg_data;
			end else if (cfg_index == tsm_pkg::REG_SHT_TOL) begin
				tol_s_q <= cfg_data;
			end
		end
	end

	// sequencer for load, clear, query scan and match evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			div_go_q    <= 1'b0;
			sin_go_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			sin_go_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						lng_q   <= long_side;
						mid_q   <= middle_side;
						sht_q   <= short_side;
						ang_q   <= orientation;
						px_q    <= pos_x;
						py_q    <= pos_y;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (op_q == tsm_pkg::OP_CLEAR) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end else if ((op_q != tsm_pkg::OP_LOAD && op_q != tsm_pkg::OP_QUERY) ||
					             lng_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						div_go_q  <= 1'b1;
						div_dvd_q <= {mid_q, 16'h0000};
						div_dvs_q <= lng_q;
						state_q   <= ST_DIV_M;
					end
				end
				ST_DIV_M: begin
					if (div_done) begin
						mr_q      <= (div_quot[47:16] != '0) ? 16'hFFFF : div_quot[15:0];
						div_go_q  <= 1'b1;
						div_dvd_q <= {sht_q, 16'h0000};
						state_q   <= ST_DIV_S;
					end
				end
				ST_DIV_S: begin
					if (div_done) begin
						sr_q <= (div_quot[47:16] != '0) ? 16'hFFFF : div_quot[15:0];
						if (op_q == tsm_pkg::OP_LOAD) begin
							state_q <= (count_q < CNT_W'(TABLE_DEPTH)) ? ST_PUSH : ST_IDLE;
						end else begin
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_PUSH: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_q == CNT_W'(TABLE_DEPTH)) begin
						state_q <= ST_FLUSH;
					end else if (hit) begin
						div_go_q  <= 1'b1;
						div_dvd_q <= {lng_q, 16'h0000};
						div_dvs_q <= head.long_side;
						state_q   <= ST_DIV_R;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DIV_R: begin
					if (div_done) begin
						r_q       <= (div_quot[47:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
						dphi_q    <= 16'(ang_q - head.orientation);
						sin_go_q  <= 1'b1;
						sin_ang_q <= 16'(ang_q - head.orientation);
						state_q   <= ST_SIN_S;
					end
				end
				ST_SIN_S: begin
					if (sin_done) begin
						s_q       <= sin_val;
						sin_go_q  <= 1'b1;
						sin_ang_q <= 16'(dphi_q + tsm_pkg::QUARTER);
						state_q   <= ST_SIN_C;
					end
				end
				ST_SIN_C: begin
					if (sin_done) begin
						c_q     <= sin_val;
						state_q <= ST_MUL0;
					end
				end
				ST_MUL0: begin
					p0_q    <= $signed(head.pos_x) * c_q;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					p1_q    <= $signed(head.pos_y) * s_q;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					p2_q    <= $signed(head.pos_y) * c_q;
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					p3_q    <= $signed(head.pos_x) * s_q;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					xneg_q  <= vx[64];
					yneg_q  <= vy[64];
					xmag_q  <= ax_mag[62:30];
					ymag_q  <= ay_mag[62:30];
					state_q <= ST_SCL0;
				end
				ST_SCL0: begin
					sxh_q   <= xmag_q * r_q[31:16];
					state_q <= ST_SCL1;
				end
				ST_SCL1: begin
					sxl_q   <= xmag_q * r_q[15:0];
					state_q <= ST_SCL2;
				end
				ST_SCL2: begin
					syh_q   <= ymag_q * r_q[31:16];
					state_q <= ST_SCL3;
				end
				ST_SCL3: begin
					syl_q   <= ymag_q * r_q[15:0];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					res_q.scale_ratio <= r_q;
					res_q.rotation    <= dphi_q;
					res_q.shift_x     <= sat_x;
					res_q.shift_y     <= sat_y;
					state_q           <= ST_EMIT;
				end
				ST_EMIT: begin
					// the previous match is known not to be the last
					if (!pend_v_q || slot_free) begin
						if (pend_v_q) begin
							out_q       <= pend_q;
							last_q      <= 1'b0;
							out_valid_q <= 1'b1;
						end
						pend_q   <= res_q;
						pend_v_q <= 1'b1;
						scan_q   <= scan_q + 1'b1;
						state_q  <= ST_SCAN;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						out_q       <= pend_q;
						last_q      <= 1'b1;
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign scale_ratio = out_q.scale_ratio;
	assign rotation    = out_q.rotation;
	assign shift_x     = out_q.shift_x;
	assign shift_y     = out_q.shift_y;
	assign last_match  = last_q;

endmodule

[rtl/tsm_checker.sv]
// ----------------------------------------------------------------------------
// tsm_props: port-level checks of the triangle similarity matcher
// Watches the handshakes over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tsm_props (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [31:0]        scale_ratio,
	input logic signed [15:0] rotation,
	input logic signed [31:0] shift_x,
	input logic signed [31:0] shift_y,
	input logic               last_match
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scale_ratio) &&
		$stable(rotation) && $stable(shift_x) && $stable(shift_y) &&
		$stable(last_match))
		else $error("stalled result word changed");

	// one word at a time: an accepted word stalls the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting a word");

	// results appear only while a word is in work
	a_result_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word without a word in work");

endmodule

bind triangle_similarity_matcher_top tsm_props u_tsm_props (.*);
